@@ rtl/core/cgfe_pkg.sv @@
// Shared types and constants of the cell grid formula evaluator.
package cgfe_pkg;

	typedef logic [5:0] row_t;
	typedef logic [5:0] col_t;

	typedef struct packed {
		logic        err;
		logic [31:0] value;
	} cell_t;

	typedef struct packed {
		logic  rd;
		row_t  rd_row;
		col_t  rd_col;
		logic  wr;
		row_t  wr_row;
		col_t  wr_col;
		cell_t wr_cell;
	} mem_req_t;

	localparam logic [3:0] MODE_COPY  = 4'd0;
	localparam logic [3:0] MODE_ADD   = 4'd1;
	localparam logic [3:0] MODE_SUB   = 4'd2;
	localparam logic [3:0] MODE_MUL   = 4'd3;
	localparam logic [3:0] MODE_DIV   = 4'd4;
	localparam logic [3:0] MODE_SUM   = 4'd5;
	localparam logic [3:0] MODE_MIN   = 4'd6;
	localparam logic [3:0] MODE_MAX   = 4'd7;
	localparam logic [3:0] MODE_AVG   = 4'd8;
	localparam logic [3:0] MODE_STDEV = 4'd9;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam int CNT_W  = 13;
	localparam int ESUM_W = 44;
	localparam int SQ_W   = 75;
	localparam int WIDE_W = 88;
	localparam int ROOT_W = 44;
	localparam int DIVN_W = 44;
	localparam int STEP_W = 6;

endpackage

@@ rtl/core/cell_grid_formula_evaluator_core.sv @@
// Top level of the cell grid formula evaluator: sequencer, cell store and arithmetic units.
//
// One formula at a time. After reset a clearing pass zeroes the cell store, one cell per
// cycle, while in_ready stays low (configuration writes are taken). Copy, add, subtract
// and multiply are computed in the sequencer; division uses the 44-step divider. A range
// reduction reads one cell per cycle from the store's single read port; AVG then uses the
// divider, and STDEV two 44-step shift-add multiplies, a 44-step square root and the
// divider. The result waits in an output register, so the next formula may be
// transferred while it is still pending.
module cell_grid_formula_evaluator_core import cgfe_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [6:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         mode,
	input  logic               left_is_cell,
	input  logic signed [31:0] left_const,
	input  logic [5:0]         left_row,
	input  logic [5:0]         left_col,
	input  logic               right_is_cell,
	input  logic signed [31:0] right_const,
	input  logic [5:0]         right_row,
	input  logic [5:0]         right_col,
	input  logic [5:0]         dest_row,
	input  logic [5:0]         dest_col,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic               result_error
);

	typedef enum logic [3:0] {
		S_IDLE, S_BL, S_BR, S_BX, S_BOP, S_DIV, S_RRD, S_RDRN, S_REND,
		S_NQ, S_MS, S_DIFF, S_SQRT, S_FIN
	} state_t;

	function automatic logic oob(input row_t r, input col_t c,
			input logic [6:0] nr, input logic [6:0] nc);
		return (7'(r) >= nr) || (7'(c) >= nc) ||
			(32'(r) >= MAX_ROWS) || (32'(c) >= MAX_COLS);
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? 32'(-v) : v;
	endfunction

	state_t             state_q;
	logic [6:0]         rows_q;
	logic [6:0]         cols_q;
	logic [3:0]         mode_q;
	logic               lic_q;
	logic               ric_q;
	logic               loob_q;
	logic               roob_q;
	logic [31:0]        lconst_q;
	logic [31:0]        rconst_q;
	row_t               lrow_q;
	col_t               lcol_q;
	row_t               rrow_q;
	col_t               rcol_q;
	row_t               trow_q;
	col_t               tcol_q;
	logic [31:0]        lv_q;
	logic [31:0]        rv_q;
	logic               lerr_q;
	logic               rerr_q;
	logic [31:0]        res_q;
	logic               err_q;
	logic               neg_q;
	row_t               r_q;
	col_t               c_q;
	col_t               c1_q;
	row_t               r2_q;
	col_t               c2_q;
	logic               first_q;
	logic [31:0]        wsum_q;
	logic [ESUM_W-1:0]  esum_q;
	logic [SQ_W-1:0]    sq_q;
	logic [31:0]        best_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               v_s1;
	logic               oob_s1;
	logic               v_s2;
	logic [31:0]        mag_s2;
	logic               v_s3;
	logic [63:0]        prod_s3;
	logic [WIDE_W-1:0]  nq_q;
	logic [WIDE_W-1:0]  diff_q;
	logic               div_start_q;
	logic [DIVN_W-1:0]  div_n_q;
	logic [31:0]        div_d_q;
	logic               mul_start_q;
	logic [WIDE_W-1:0]  mul_a_q;
	logic [ROOT_W-1:0]  mul_b_q;
	logic               sqrt_start_q;
	logic               out_valid_q;
	logic [31:0]        out_value_q;
	logic               out_err_q;

	mem_req_t           mreq;
	cell_t              mrdata;
	logic               mem_ready;
	logic               div_done;
	logic [DIVN_W-1:0]  div_q;
	logic               mul_done;
	logic [WIDE_W-1:0]  mul_p;
	logic               sqrt_done;
	logic [ROOT_W-1:0]  sqrt_root;

	logic               in_xfer;
	logic               in_loob;
	logic               in_roob;
	logic               in_empty;
	logic               lerr_rd;
	logic [31:0]        lv_rd;
	logic               rerr_rd;
	logic [31:0]        rv_rd;
	logic               cell_e;
	logic [31:0]        cell_v;
	logic [ESUM_W-1:0]  ms;
	logic [31:0]        div_q32;

	cgfe_cell_mem #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_mem (
		.clk(clk), .arst_n(arst_n), .req(mreq), .rdata(mrdata), .ready(mem_ready)
	);

	cgfe_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .dividend(div_n_q),
		.divisor(div_d_q), .done(div_done), .quotient(div_q)
	);

	cgfe_mulser u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q), .a(mul_a_q), .b(mul_b_q),
		.done(mul_done), .product(mul_p)
	);

	cgfe_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start_q), .radicand(diff_q),
		.done(sqrt_done), .root(sqrt_root)
	);

	assign in_ready = (state_q == S_IDLE) && mem_ready;
	assign in_xfer  = in_valid && in_ready;
	assign in_loob  = oob(left_row, left_col, rows_q, cols_q);
	assign in_roob  = oob(right_row, right_col, rows_q, cols_q);
	assign in_empty = (left_row > right_row) || (left_col > right_col);

	assign lerr_rd = lic_q && (loob_q || mrdata.err);
	assign lv_rd   = lic_q ? (lerr_rd ? 32'd0 : mrdata.value) : lconst_q;
	assign rerr_rd = ric_q && (roob_q || mrdata.err);
	assign rv_rd   = ric_q ? (rerr_rd ? 32'd0 : mrdata.value) : rconst_q;

	assign cell_e = oob_s1 || mrdata.err;
	assign cell_v = cell_e ? 32'd0 : mrdata.value;

	assign ms      = esum_q[ESUM_W-1] ? ESUM_W'(-esum_q) : esum_q;
	assign div_q32 = div_q[31:0];

	always_comb begin
		mreq         = '0;
		mreq.wr_row  = trow_q;
		mreq.wr_col  = tcol_q;
		mreq.wr_cell = '{err: err_q, value: (err_q ? 32'd0 : res_q)};
		case (state_q)
			S_BL: begin
				mreq.rd     = lic_q && !loob_q;
				mreq.rd_row = lrow_q;
				mreq.rd_col = lcol_q;
			end
			S_BR: begin
				mreq.rd     = ric_q && !roob_q;
				mreq.rd_row = rrow_q;
				mreq.rd_col = rcol_q;
			end
			S_RRD: begin
				mreq.rd     = !oob(r_q, c_q, rows_q, cols_q);
				mreq.rd_row = r_q;
				mreq.rd_col = c_q;
			end
			S_FIN: begin
				mreq.wr = (!out_valid_q || out_ready) &&
					(32'(trow_q) < MAX_ROWS) && (32'(tcol_q) < MAX_COLS);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rows_q       <= 7'd64;
			cols_q       <= 7'd64;
			out_valid_q  <= 1'b0;
			div_start_q  <= 1'b0;
			mul_start_q  <= 1'b0;
			sqrt_start_q <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_ROWS) begin
					rows_q <= cfg_wdata;
				end else begin
					cols_q <= cfg_wdata;
				end
			end

			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end

			// range pipeline: read data, magnitude, square
			v_s1    <= (state_q == S_RRD);
			oob_s1  <= oob(r_q, c_q, rows_q, cols_q);
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			mag_s2  <= abs32(cell_v);
			prod_s3 <= mag_s2 * mag_s2;
			if (v_s1) begin
				err_q  <= err_q | cell_e;
				wsum_q <= wsum_q + cell_v;
				esum_q <= esum_q + ESUM_W'(signed'(cell_v));
				cnt_q  <= cnt_q + 1'b1;
				first_q <= 1'b0;
				if (first_q ||
						((mode_q == MODE_MIN) && ($signed(cell_v) < $signed(best_q))) ||
						((mode_q == MODE_MAX) && ($signed(cell_v) > $signed(best_q)))) begin
					best_q <= cell_v;
				end
			end
			if (v_s3) begin
				sq_q <= sq_q + SQ_W'(prod_s3);
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						mode_q   <= mode;
						lic_q    <= left_is_cell;
						ric_q    <= right_is_cell;
						loob_q   <= in_loob;
						roob_q   <= in_roob;
						lconst_q <= left_const;
						rconst_q <= right_const;
						lrow_q   <= left_row;
						lcol_q   <= left_col;
						rrow_q   <= right_row;
						rcol_q   <= right_col;
						trow_q   <= dest_row;
						tcol_q   <= dest_col;
						res_q    <= '0;
						err_q    <= !(mode inside {[MODE_COPY:MODE_STDEV]});
						r_q      <= left_row;
						c_q      <= left_col;
						c1_q     <= left_col;
						r2_q     <= in_empty ? left_row : right_row;
						c2_q     <= in_empty ? left_col : right_col;
						first_q  <= 1'b1;
						wsum_q   <= '0;
						esum_q   <= '0;
						sq_q     <= '0;
						best_q   <= '0;
						cnt_q    <= '0;
						if (mode inside {[MODE_COPY:MODE_DIV]}) begin
							state_q <= S_BL;
						end else if (mode inside {MODE_MIN, MODE_MAX}) begin
							state_q <= S_RRD;
						end else if (mode inside {MODE_SUM, MODE_AVG, MODE_STDEV}) begin
							state_q <= in_empty ? S_FIN : S_RRD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_BL: begin
					state_q <= S_BR;
				end
				S_BR: begin
					lv_q    <= lv_rd;
					lerr_q  <= lerr_rd;
					state_q <= S_BX;
				end
				S_BX: begin
					rv_q    <= rv_rd;
					rerr_q  <= rerr_rd;
					state_q <= S_BOP;
				end
				S_BOP: begin
					if (mode_q == MODE_COPY) begin
						res_q   <= lv_q;
						err_q   <= lerr_q;
						state_q <= S_FIN;
					end else if (lerr_q || rerr_q) begin
						err_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						case (mode_q)
							MODE_ADD: begin
								res_q   <= lv_q + rv_q;
								state_q <= S_FIN;
							end
							MODE_SUB: begin
								res_q   <= lv_q - rv_q;
								state_q <= S_FIN;
							end
							MODE_MUL: begin
								res_q   <= lv_q * rv_q;
								state_q <= S_FIN;
							end
							default: begin
								if (rv_q == '0) begin
									err_q   <= 1'b1;
									state_q <= S_FIN;
								end else begin
									neg_q       <= lv_q[31] ^ rv_q[31];
									div_n_q     <= DIVN_W'(abs32(lv_q));
									div_d_q     <= abs32(rv_q);
									div_start_q <= 1'b1;
									state_q     <= S_DIV;
								end
							end
						endcase
					end
				end
				S_DIV: begin
					div_start_q <= 1'b0;
					if (div_done) begin
						res_q   <= neg_q ? 32'(-div_q32) : div_q32;
						state_q <= S_FIN;
					end
				end
				S_RRD: begin
					if (c_q == c2_q) begin
						c_q <= c1_q;
						r_q <= r_q + 1'b1;
						if (r_q == r2_q) begin
							state_q <= S_RDRN;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				S_RDRN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_REND;
					end
				end
				S_REND: begin
					if (err_q) begin
						state_q <= S_FIN;
					end else begin
						case (mode_q)
							MODE_SUM: begin
								res_q   <= wsum_q;
								state_q <= S_FIN;
							end
							MODE_MIN, MODE_MAX: begin
								res_q   <= best_q;
								state_q <= S_FIN;
							end
							MODE_AVG: begin
								neg_q       <= wsum_q[31];
								div_n_q     <= DIVN_W'(abs32(wsum_q));
								div_d_q     <= 32'(cnt_q);
								div_start_q <= 1'b1;
								state_q     <= S_DIV;
							end
							default: begin
								mul_a_q     <= WIDE_W'(sq_q);
								mul_b_q     <= ROOT_W'(cnt_q);
								mul_start_q <= 1'b1;
								state_q     <= S_NQ;
							end
						endcase
					end
				end
				S_NQ: begin
					if (mul_done) begin
						nq_q        <= mul_p;
						mul_a_q     <= WIDE_W'(ms);
						mul_b_q     <= ms;
						mul_start_q <= 1'b1;
						state_q     <= S_MS;
					end else begin
						mul_start_q <= 1'b0;
					end
				end
				S_MS: begin
					mul_start_q <= 1'b0;
					if (mul_done) begin
						diff_q  <= nq_q - mul_p;
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					sqrt_start_q <= 1'b1;
					state_q      <= S_SQRT;
				end
				S_SQRT: begin
					sqrt_start_q <= 1'b0;
					if (sqrt_done) begin
						neg_q       <= 1'b0;
						div_n_q     <= sqrt_root;
						div_d_q     <= 32'(cnt_q);
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_value_q <= err_q ? 32'd0 : res_q;
						out_err_q   <= err_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign result_error = out_err_q;

endmodule

@@ rtl/core/cgfe_cell_mem.sv @@
// Cell store: one-port-read, one-port-write memory with a clearing pass after reset.
module cgfe_cell_mem import cgfe_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output cell_t    rdata,
	output logic     ready
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cell_t          mem [DEPTH];
	cell_t          rdata_q;
	logic [AW-1:0]  clr_q;
	logic           clr_busy_q;
	logic [AW-1:0]  raddr;
	logic [AW-1:0]  waddr;

	assign raddr = AW'(int'(req.rd_row) * MAX_COLS + int'(req.rd_col));
	assign waddr = AW'(int'(req.wr_row) * MAX_COLS + int'(req.wr_col));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_q] <= '0;
		end else if (req.wr) begin
			mem[waddr] <= req.wr_cell;
		end
		if (req.rd) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
	assign ready = !clr_busy_q;

endmodule

@@ rtl/core/cgfe_div.sv @@
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module cgfe_div import cgfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVN_W-1:0] dividend,
	input  logic [31:0]       divisor,
	output logic              done,
	output logic [DIVN_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [32:0]       rem_q;
	logic [DIVN_W-1:0] n_q;
	logic [31:0]       d_q;
	logic [32:0]       rem_sh;
	logic              ge;

	assign rem_sh = {rem_q[31:0], n_q[DIVN_W-1]};
	assign ge     = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == STEP_W'(DIVN_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIVN_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			n_q   <= dividend;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, d_q} : rem_sh;
			n_q   <= {n_q[DIVN_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = n_q;

endmodule

@@ rtl/core/cgfe_isqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
module cgfe_isqrt import cgfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [46:0]       rem_q;
	logic [WIDE_W-1:0] x_q;
	logic [ROOT_W-1:0] root_q;
	logic [46:0]       rem_sh;
	logic [46:0]       trial;
	logic              ge;

	assign rem_sh = {rem_q[44:0], x_q[WIDE_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == STEP_W'(ROOT_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			x_q    <= radicand;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			x_q    <= {x_q[WIDE_W-3:0], 2'b00};
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ rtl/core/cgfe_mulser.sv @@
// Shift-and-add wide multiplier, one multiplier bit per cycle.
module cgfe_mulser import cgfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] a,
	input  logic [ROOT_W-1:0] b,
	output logic              done,
	output logic [WIDE_W-1:0] product
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [WIDE_W-1:0] a_q;
	logic [ROOT_W-1:0] b_q;
	logic [WIDE_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == STEP_W'(ROOT_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[WIDE_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[ROOT_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

@@ rtl/core/cgfe_checker.sv @@
// Port-level checks of the cell grid formula evaluator, bound to its top level.
module cgfe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] result_value,
	input logic               result_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value) &&
			$stable(result_error))
		else $error("pending result changed before transfer");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_error |-> result_value == 32'sd0)
		else $error("error result carries a nonzero value");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second formula taken while one is in work");

	a_no_instant_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared in the cycle after its transfer");

endmodule

bind cell_grid_formula_evaluator_core cgfe_checker u_cgfe_checker (.*);

@@ test/cell_grid_formula_evaluator_core_tb.sv @@
// Self-checking testbench for the cell grid formula evaluator core.
module cell_grid_formula_evaluator_core_tb;
	import cgfe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_DIM = 64;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam logic [3:0] MODE_UNUSED_FIRST = 4'd10;
	localparam logic [3:0] MODE_UNUSED_LAST = 4'd15;

	typedef struct {
		logic [3:0]  mode;
		logic        l_cell;
		logic [31:0] l_const;
		logic [5:0]  l_row;
		logic [5:0]  l_col;
		logic        r_cell;
		logic [31:0] r_const;
		logic [5:0]  r_row;
		logic [5:0]  r_col;
		logic [5:0]  t_row;
		logic [5:0]  t_col;
	} formula_t;

	typedef struct {
		logic [31:0] value;
		logic        err;
	} echo_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_idx;
	logic [6:0]         cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         mode;
	logic               left_is_cell;
	logic signed [31:0] left_const;
	logic [5:0]         left_row;
	logic [5:0]         left_col;
	logic               right_is_cell;
	logic signed [31:0] right_const;
	logic [5:0]         right_row;
	logic [5:0]         right_col;
	logic [5:0]         dest_row;
	logic [5:0]         dest_col;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] result_value;
	logic               result_error;

	logic [31:0] grid_value [GRID_DIM*GRID_DIM];
	logic        grid_err [GRID_DIM*GRID_DIM];
	logic [6:0]  rows_cfg;
	logic [6:0]  cols_cfg;
	echo_t       expected_echoes [$];
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          recv_hold;
	int          fail_count = 0;
	int          cycle_count = 0;

	cell_grid_formula_evaluator_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .left_is_cell(left_is_cell), .left_const(left_const),
		.left_row(left_row), .left_col(left_col),
		.right_is_cell(right_is_cell), .right_const(right_const),
		.right_row(right_row), .right_col(right_col),
		.dest_row(dest_row), .dest_col(dest_col),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .result_error(result_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit read_grid(input int r, input int c, output logic [31:0] v);
		int nr;
		int nc;
		nr = rows_cfg < GRID_DIM ? rows_cfg : GRID_DIM;
		nc = cols_cfg < GRID_DIM ? cols_cfg : GRID_DIM;
		v = '0;
		if (r >= nr || c >= nc) return 1'b1;
		if (grid_err[r*GRID_DIM + c]) return 1'b1;
		v = grid_value[r*GRID_DIM + c];
		return 1'b0;
	endfunction

	function automatic logic [31:0] quotient_trunc(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ua;
		logic [31:0] ub;
		logic [31:0] q;
		ua = a[31] ? -a : a;
		ub = b[31] ? -b : b;
		q = ua / ub;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic logic [63:0] root_floor(input logic [127:0] a);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= a) r = c;
		end
		return r;
	endfunction

	function automatic bit reduce_range(input formula_t f, output logic [31:0] res);
		logic [31:0]  v;
		logic [31:0]  wsum;
		logic [31:0]  count;
		longint       best;
		longint       exact_sum;
		longint       s;
		logic [63:0]  m;
		logic [127:0] sq;
		logic [127:0] ms;
		res = '0;
		wsum = '0;
		count = '0;
		exact_sum = 0;
		sq = '0;
		best = 0;
		if (f.mode == MODE_MIN || f.mode == MODE_MAX) begin
			if (read_grid(f.l_row, f.l_col, v)) return 1'b1;
			best = longint'(signed'(v));
		end
		for (int r = f.l_row; r <= f.r_row; r++) begin
			for (int c = f.l_col; c <= f.r_col; c++) begin
				if (read_grid(r, c, v)) begin
					res = '0;
					return 1'b1;
				end
				s = longint'(signed'(v));
				if (f.mode == MODE_MIN && s < best) best = s;
				if (f.mode == MODE_MAX && s > best) best = s;
				wsum += v;
				exact_sum += s;
				m = s < 0 ? -s : s;
				sq += {64'd0, m} * {64'd0, m};
				count++;
			end
		end
		if (f.mode == MODE_SUM) res = wsum;
		else if (f.mode == MODE_MIN || f.mode == MODE_MAX) res = best[31:0];
		else if (count == 0) res = '0;
		else if (f.mode == MODE_AVG) res = quotient_trunc(wsum, count);
		else begin
			ms = exact_sum < 0 ? -exact_sum : exact_sum;
			res = 32'(root_floor(sq * count - ms * ms) / count);
		end
		return 1'b0;
	endfunction

	function automatic echo_t predict_formula(input formula_t f);
		echo_t       e;
		logic [31:0] lv;
		logic [31:0] rv;
		bit          lerr;
		bit          rerr;
		lv = f.l_const;
		rv = f.r_const;
		lerr = 1'b0;
		rerr = 1'b0;
		e.value = '0;
		e.err = 1'b0;
		if (f.mode <= MODE_DIV) begin
			if (f.l_cell) lerr = read_grid(f.l_row, f.l_col, lv);
			if (f.r_cell) rerr = read_grid(f.r_row, f.r_col, rv);
			if (f.mode == MODE_COPY) begin
				e.err = lerr;
				e.value = lv;
			end else if (lerr || rerr) e.err = 1'b1;
			else if (f.mode == MODE_ADD) e.value = lv + rv;
			else if (f.mode == MODE_SUB) e.value = lv - rv;
			else if (f.mode == MODE_MUL) e.value = lv * rv;
			else if (rv == 0) e.err = 1'b1;
			else e.value = quotient_trunc(lv, rv);
		end else if (f.mode <= MODE_STDEV) begin
			e.err = reduce_range(f, e.value);
		end else begin
			e.err = 1'b1;
		end
		if (e.err) e.value = '0;
		grid_value[f.t_row*GRID_DIM + f.t_col] = e.value;
		grid_err[f.t_row*GRID_DIM + f.t_col] = e.err;
		return e;
	endfunction

	always @(negedge clk) begin
		out_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		echo_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_echoes.size() == 0) begin
				$display("%0t: unexpected result value=%0d error=%0b", $time,
					result_value, result_error);
				fail_count++;
			end else begin
				e = expected_echoes.pop_front();
				if (result_value !== e.value) begin
					$display("%0t: result_value expected %0d actual %0d", $time,
						signed'(e.value), result_value);
					fail_count++;
				end
				if (result_error !== e.err) begin
					$display("%0t: result_error expected %0b actual %0b", $time,
						e.err, result_error);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("cell_grid_formula_evaluator_core verification failed");
			$finish;
		end
	end

	function automatic formula_t make_formula(input logic [3:0] md, input logic lc_cell,
			input logic [31:0] lk, input int lr, input int lc, input logic rc_cell,
			input logic [31:0] rk, input int rr, input int rc, input int tr, input int tc);
		formula_t f;
		f.mode = md;
		f.l_cell = lc_cell;
		f.l_const = lk;
		f.l_row = 6'(lr);
		f.l_col = 6'(lc);
		f.r_cell = rc_cell;
		f.r_const = rk;
		f.r_row = 6'(rr);
		f.r_col = 6'(rc);
		f.t_row = 6'(tr);
		f.t_col = 6'(tc);
		return f;
	endfunction

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($urandom_range(0, 40)) - 32'd20;
			2: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	function automatic int random_index();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
	endfunction

	function automatic formula_t random_formula();
		formula_t f;
		int       k;
		k = $urandom_range(0, 19);
		f.mode = (k < 18) ? 4'(k % 10) : 4'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
		f.l_cell = $urandom_range(0, 2) != 0;
		f.r_cell = $urandom_range(0, 2) != 0;
		f.l_const = random_word();
		f.r_const = random_word();
		f.l_row = 6'(random_index());
		f.l_col = 6'(random_index());
		f.r_row = 6'(random_index());
		f.r_col = 6'(random_index());
		if (f.mode >= MODE_SUM && f.mode <= MODE_STDEV) begin
			f.l_row = 6'($urandom_range(0, 7));
			f.l_col = 6'($urandom_range(0, 7));
			f.r_row = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 7)) :
				f.l_row + 6'($urandom_range(0, 4));
			f.r_col = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 7)) :
				f.l_col + 6'($urandom_range(0, 4));
		end
		f.t_row = 6'(random_index());
		f.t_col = 6'(random_index());
		return f;
	endfunction

	task automatic send_formula(input formula_t f);
		while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
		mode = f.mode;
		left_is_cell = f.l_cell;
		left_const = f.l_const;
		left_row = f.l_row;
		left_col = f.l_col;
		right_is_cell = f.r_cell;
		right_const = f.r_const;
		right_row = f.r_row;
		right_col = f.r_col;
		dest_row = f.t_row;
		dest_col = f.t_col;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_echoes.push_back(predict_formula(f));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		wait (expected_echoes.size() == 0);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] val);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = val;
		@(posedge clk);
		if (idx == REG_ROWS) rows_cfg = val;
		else cols_cfg = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_grid_limits(input logic [6:0] rows, input logic [6:0] cols);
		drain();
		write_reg(REG_ROWS, rows);
		write_reg(REG_COLS, cols);
	endtask

	task automatic test_directed();
		logic [31:0] imin;
		logic [31:0] imax;
		imin = 32'h8000_0000;
		imax = 32'h7FFF_FFFF;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_formula(make_formula(MODE_COPY, 0, imin, 0, 0, 0, 0, 0, 0, 0, 0));
		send_formula(make_formula(MODE_COPY, 0, imax, 0, 0, 0, 0, 0, 0, 0, 1));
		send_formula(make_formula(MODE_COPY, 0, '1, 0, 0, 0, 0, 0, 0, 1, 0));
		send_formula(make_formula(MODE_COPY, 0, 7, 0, 0, 0, 0, 0, 0, 1, 1));
		send_formula(make_formula(MODE_ADD, 1, 0, 0, 0, 1, 0, 0, 1, 2, 0));
		send_formula(make_formula(MODE_SUB, 1, 0, 0, 0, 1, 0, 1, 1, 2, 1));
		send_formula(make_formula(MODE_MUL, 1, 0, 0, 1, 1, 0, 0, 1, 2, 2));
		send_formula(make_formula(MODE_DIV, 1, 0, 0, 0, 0, '1, 0, 0, 2, 3));
		send_formula(make_formula(MODE_DIV, 0, -7, 0, 0, 0, 2, 0, 0, 2, 4));
		send_formula(make_formula(MODE_DIV, 0, 5, 0, 0, 0, 0, 0, 0, 3, 0));
		send_formula(make_formula(MODE_ADD, 1, 0, 3, 0, 0, 1, 0, 0, 3, 1));
		send_formula(make_formula(MODE_COPY, 1, 0, 1, 1, 1, 0, 3, 0, 3, 2));
		send_formula(make_formula(MODE_UNUSED_FIRST, 0, 1, 0, 0, 0, 1, 0, 0, 3, 3));
		send_formula(make_formula(MODE_UNUSED_LAST, 0, 1, 0, 0, 0, 1, 0, 0, 3, 4));
		send_formula(make_formula(MODE_SUM, 0, 0, 0, 0, 0, 0, 1, 1, 4, 0));
		send_formula(make_formula(MODE_MIN, 0, 0, 0, 0, 0, 0, 1, 1, 4, 1));
		send_formula(make_formula(MODE_MAX, 0, 0, 0, 0, 0, 0, 1, 1, 4, 2));
		send_formula(make_formula(MODE_AVG, 0, 0, 0, 0, 0, 0, 1, 1, 4, 3));
		send_formula(make_formula(MODE_STDEV, 0, 0, 0, 0, 0, 0, 1, 1, 4, 4));
		send_formula(make_formula(MODE_SUM, 0, 0, 1, 1, 0, 0, 0, 0, 5, 0));
		send_formula(make_formula(MODE_MIN, 0, 0, 1, 1, 0, 0, 0, 0, 5, 1));
		send_formula(make_formula(MODE_MAX, 0, 0, 3, 0, 0, 0, 0, 0, 5, 2));
		send_formula(make_formula(MODE_STDEV, 0, 0, 0, 0, 0, 0, 63, 63, 63, 63));
		set_grid_limits(0, 64);
		send_formula(make_formula(MODE_COPY, 1, 0, 0, 0, 0, 0, 0, 0, 5, 3));
		set_grid_limits(64, 0);
		send_formula(make_formula(MODE_AVG, 0, 0, 0, 0, 0, 0, 1, 1, 5, 4));
	endtask

	task automatic test_random(input int items, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (items) send_formula(random_formula());
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				recv_hold = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				recv_hold = 1'b0;
			end
			repeat (8) send_formula(random_formula());
		join
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_ROWS;
		cfg_wdata = '0;
		in_valid = 1'b0;
		mode = MODE_COPY;
		left_is_cell = 1'b0;
		left_const = '0;
		left_row = '0;
		left_col = '0;
		right_is_cell = 1'b0;
		right_const = '0;
		right_row = '0;
		right_col = '0;
		dest_row = '0;
		dest_col = '0;
		recv_hold = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		rows_cfg = 7'd64;
		cols_cfg = 7'd64;
		foreach (grid_value[i]) begin
			grid_value[i] = '0;
			grid_err[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		set_grid_limits(6, 5);
		test_random(30, 0, 0);
		set_grid_limits(127, 127);
		test_random(30, 58, 0);
		set_grid_limits(1, 64);
		test_random(30, 0, 58);
		set_grid_limits(64, 1);
		test_random(15, 35, 35);
		set_grid_limits(64, 64);
		test_random(20, 35, 35);
		test_backpressure();
		drain();

		if (fail_count == 0) begin
			$display("cell_grid_formula_evaluator_core verification clean");
		end else begin
			$display("cell_grid_formula_evaluator_core verification failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/cgfe_pkg.sv
rtl/core/cgfe_cell_mem.sv
rtl/core/cgfe_div.sv
rtl/core/cgfe_isqrt.sv
rtl/core/cgfe_mulser.sv
rtl/core/cell_grid_formula_evaluator_core.sv
rtl/core/cgfe_checker.sv
test/cell_grid_formula_evaluator_core_tb.sv
